### rtl/core/iprf_pkg.sv
// ----------------------------------------------------------------------------
// IP range filter package
// Shared field widths, operation codes and the transfer and chain record
// types used by the range filter cells and the top level.
// ----------------------------------------------------------------------------
package iprf_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int OP_W        = 3;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_FIELD_W = 7;

  // Largest run a single read back may deliver.
  localparam logic [CNT_FIELD_W-1:0] MAX_READ = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_APPEND      = 3'd1,
    OP_CHECK_ALIVE = 3'd2,
    OP_CHECK_ONE   = 3'd3,
    OP_READ        = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic                   table_select;
    logic [ADDR_W-1:0]      range_start;
    logic [ADDR_W-1:0]      range_end;
    logic [ADDR_W-1:0]      address;
    logic [IDX_W-1:0]       entry_index;
    logic [CNT_FIELD_W-1:0] entry_count;
  } in_item_t;

  typedef struct packed {
    logic                   matched;
    logic                   status;
    logic [ADDR_W-1:0]      entry_first;
    logic [ADDR_W-1:0]      entry_last;
    logic [CNT_FIELD_W-1:0] returned_count;
    logic                   final_item;
  } out_item_t;

  // Request token that walks forward along the row of cells.
  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic                   tsel;
    logic [ADDR_W-1:0]      first;
    logic [ADDR_W-1:0]      last;
    logic [ADDR_W-1:0]      addr;
    logic [IDX_W-1:0]       idx;
    logic [CNT_FIELD_W-1:0] n;
    logic                   full;
    logic                   hit_allow;
    logic                   hit_block;
  } token_t;

  // Result record that walks back toward the head of the row.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } back_t;

endpackage

### rtl/core/ip_range_allow_block_filter_unit.sv
// ----------------------------------------------------------------------------
// IP range allow/block filter
// Allow and block tables of inclusive IPv4 ranges held in a row of cells,
// with clear, append, check and read back operations.
// ----------------------------------------------------------------------------
// The block works on one operation at a time: a new input transfer is taken
// only after the last result of the previous one has been transferred out.
// Each of the TABLE_DEPTH cells holds entry k of both tables. An accepted
// request becomes a token that moves one cell per cycle down the row,
// collecting range hits and writing appended entries; results come back on
// a return lane that moves one cell per cycle toward the head and feeds the
// output register; an output stall while a result waits holds both. Clear,
// append, check and unknown operations give a single result, which starts
// back when the token reaches the tail of the row. A read back delivers its
// entries in index order, each put on the lane as the token passes its
// cell; a read back that returns nothing answers from the tail. The token
// of a finished read back may still be passing down the row when the next
// request enters; it no longer touches any cell. The row and the return lane
// are the only timing that matters. The tables come out of reset empty;
// stored values need no clearing pass because only entries below each
// table's count are visible.
// ----------------------------------------------------------------------------
module ip_range_allow_block_filter_unit import iprf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W) + 1;

  // Table counts, operation in flight and output register.
  logic [CNT_W-1:0] allow_used_q, allow_used_d;
  logic [CNT_W-1:0] block_used_q, block_used_d;
  logic             busy_q, busy_d;
  logic             out_vld_q;
  out_item_t        out_item_q;

  logic             in_accept, out_xfer, adv;
  logic [CNT_W-1:0] used_sel;
  logic             full;
  logic [CMP_W-1:0] idx_e, used_e, cnt_e, avail_e, n_e;
  op_e              in_op;

  token_t                  token_w [TABLE_DEPTH+1];
  back_t                   back_w  [TABLE_DEPTH+1];

  assign in_accept = in_valid_i && !busy_q;
  assign out_xfer  = out_vld_q && !out_stall_i;
  // Hold the whole row while a result waits at the output.
  assign adv       = !out_vld_q || !out_stall_i;

  assign in_op     = op_e'(in_item_i.operation);
  assign used_sel  = in_item_i.table_select ? block_used_q : allow_used_q;
  assign full      = (used_sel == CNT_W'(TABLE_DEPTH));

  // Clip the read back run to what is stored from the start index on and to MAX_READ.
  always_comb begin
    idx_e   = CMP_W'(in_item_i.entry_index);
    used_e  = CMP_W'(used_sel);
    cnt_e   = CMP_W'(in_item_i.entry_count);
    avail_e = (idx_e < used_e) ? (used_e - idx_e) : '0;
    n_e     = (cnt_e < avail_e) ? cnt_e : avail_e;
    if (n_e > CMP_W'(MAX_READ)) begin
      n_e = CMP_W'(MAX_READ);
    end
  end

  // Build the token that enters the first cell.
  always_comb begin
    token_w[0]           = '0;
    token_w[0].valid     = in_accept;
    token_w[0].op        = in_op;
    token_w[0].tsel      = in_item_i.table_select;
    token_w[0].first     = in_item_i.range_start;
    token_w[0].last      = in_item_i.range_end;
    token_w[0].addr      = in_item_i.address;
    token_w[0].idx       = in_item_i.entry_index;
    token_w[0].n         = n_e[CNT_FIELD_W-1:0];
    token_w[0].full      = full;
  end

  // Update table counts at acceptance; the token writes the entry later.
  always_comb begin
    allow_used_d = allow_used_q;
    block_used_d = block_used_q;
    if (in_accept) begin
      if (in_op == OP_CLEAR) begin
        if (in_item_i.table_select) block_used_d = '0;
        else                        allow_used_d = '0;
      end else if ((in_op == OP_APPEND) && !full) begin
        if (in_item_i.table_select) block_used_d = block_used_q + CNT_W'(1);
        else                        allow_used_d = allow_used_q + CNT_W'(1);
      end
    end
  end

  // Turn the token around at the tail of the row.
  always_comb begin
    back_w[TABLE_DEPTH] = '0;
    if (token_w[TABLE_DEPTH].valid) begin
      unique case (token_w[TABLE_DEPTH].op)
        OP_CLEAR: begin
          back_w[TABLE_DEPTH].valid           = 1'b1;
          back_w[TABLE_DEPTH].item.final_item = 1'b1;
        end
        OP_APPEND: begin
          back_w[TABLE_DEPTH].valid           = 1'b1;
          back_w[TABLE_DEPTH].item.status     = token_w[TABLE_DEPTH].full;
          back_w[TABLE_DEPTH].item.final_item = 1'b1;
        end
        OP_CHECK_ALIVE: begin
          back_w[TABLE_DEPTH].valid           = 1'b1;
          back_w[TABLE_DEPTH].item.matched    = token_w[TABLE_DEPTH].hit_allow &
                                                !token_w[TABLE_DEPTH].hit_block;
          back_w[TABLE_DEPTH].item.final_item = 1'b1;
        end
        OP_CHECK_ONE: begin
          back_w[TABLE_DEPTH].valid           = 1'b1;
          back_w[TABLE_DEPTH].item.matched    = token_w[TABLE_DEPTH].tsel ?
                                                token_w[TABLE_DEPTH].hit_block :
                                                token_w[TABLE_DEPTH].hit_allow;
          back_w[TABLE_DEPTH].item.final_item = 1'b1;
        end
        OP_READ: begin
          // Cells deliver a nonempty run; answer here only for an empty one.
          if (token_w[TABLE_DEPTH].n == '0) begin
            back_w[TABLE_DEPTH].valid           = 1'b1;
            back_w[TABLE_DEPTH].item.final_item = 1'b1;
          end
        end
        default: begin
          back_w[TABLE_DEPTH].valid           = 1'b1;
          back_w[TABLE_DEPTH].item.final_item = 1'b1;
        end
      endcase
    end
  end

  // The first cell sees the request in its acceptance cycle, before the
  // counts register, so hand it the updated counts.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    iprf_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX       (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .used_allow_i ((k == 0) ? allow_used_d : allow_used_q),
      .used_block_i ((k == 0) ? block_used_d : block_used_q),
      .token_i      (token_w[k]),
      .token_o      (token_w[k+1]),
      .back_i       (back_w[k+1]),
      .back_o       (back_w[k])
    );
  end

  // Busy from acceptance until the final result transfers out.
  always_comb begin
    busy_d = busy_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (out_xfer && out_item_q.final_item) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_used_q <= '0;
      block_used_q <= '0;
      busy_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      allow_used_q <= allow_used_d;
      block_used_q <= block_used_d;
      busy_q       <= busy_d;
      if (adv) begin
        out_vld_q <= back_w[0].valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= back_w[0].item;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // A result only ever waits while its operation is still open.
  a_out_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> busy_q)
    else $error("result pending with no operation in flight");

  // A request only enters while no result waits at the output.
  a_accept_out_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !out_vld_q)
    else $error("request accepted with a result still pending");

  // Table counts never run past the depth.
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (allow_used_q <= CNT_W'(TABLE_DEPTH)) && (block_used_q <= CNT_W'(TABLE_DEPTH)))
    else $error("table count beyond depth");

  // An accepted transfer opens an operation.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q)
    else $error("operation not marked in flight after acceptance");

endmodule

### rtl/core/iprf_cell.sv
// ----------------------------------------------------------------------------
// IP range filter cell
// Holds one allow entry and one block entry. Updates the forward request
// token and drops read back results onto the return lane.
// ----------------------------------------------------------------------------
module iprf_cell import iprf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int INDEX       = 0,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CNT_W-1:0] used_allow_i,
  input  logic [CNT_W-1:0] used_block_i,
  input  token_t           token_i,
  output token_t           token_o,
  input  back_t            back_i,
  output back_t            back_o
);

  localparam int CMP_W = ((CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W) + 1;
  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic [ADDR_W-1:0] allow_first_q, allow_last_q;
  logic [ADDR_W-1:0] block_first_q, block_last_q;

  token_t token_d, token_q;
  back_t  back_d, back_q;
  logic   tok_vld_q, back_vld_q;

  logic [CMP_W-1:0] idx_e, end_e, used_a_e, used_b_e, used_sel_e;
  logic             live_allow, live_block, in_allow, in_block;
  logic             is_check, rd_hit, wr_en;

  always_comb begin
    idx_e      = CMP_W'(token_i.idx);
    end_e      = idx_e + CMP_W'(token_i.n);
    used_a_e   = CMP_W'(used_allow_i);
    used_b_e   = CMP_W'(used_block_i);
    used_sel_e = token_i.tsel ? used_b_e : used_a_e;
    live_allow = MY_IDX < used_a_e;
    live_block = MY_IDX < used_b_e;
    in_allow   = (allow_first_q <= token_i.addr) && (token_i.addr <= allow_last_q);
    in_block   = (block_first_q <= token_i.addr) && (token_i.addr <= block_last_q);
    is_check   = (token_i.op == OP_CHECK_ALIVE) || (token_i.op == OP_CHECK_ONE);
    rd_hit     = token_i.valid && (token_i.op == OP_READ) &&
                 (MY_IDX >= idx_e) && (MY_IDX < end_e);
    // Appended entry lands in the slot just below the updated count.
    wr_en      = adv_i && token_i.valid && (token_i.op == OP_APPEND) &&
                 !token_i.full && (MY_IDX == used_sel_e - CMP_W'(1));
  end

  always_comb begin
    token_d = token_i;
    back_d  = back_i;
    if (token_i.valid && is_check) begin
      token_d.hit_allow = token_i.hit_allow | (live_allow & in_allow);
      token_d.hit_block = token_i.hit_block | (live_block & in_block);
    end
    if (rd_hit) begin
      back_d.valid                   = 1'b1;
      back_d.item                    = '0;
      back_d.item.entry_first        = token_i.tsel ? block_first_q : allow_first_q;
      back_d.item.entry_last         = token_i.tsel ? block_last_q  : allow_last_q;
      back_d.item.returned_count     = token_i.n;
      back_d.item.final_item         = (MY_IDX == end_e - CMP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q  <= 1'b0;
      back_vld_q <= 1'b0;
    end else if (adv_i) begin
      tok_vld_q  <= token_d.valid;
      back_vld_q <= back_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      token_q <= token_d;
      back_q  <= back_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (token_i.tsel) begin
        block_first_q <= token_i.first;
        block_last_q  <= token_i.last;
      end else begin
        allow_first_q <= token_i.first;
        allow_last_q  <= token_i.last;
      end
    end
  end

  always_comb begin
    token_o       = token_q;
    token_o.valid = tok_vld_q;
    back_o        = back_q;
    back_o.valid  = back_vld_q;
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// IP range filter testbench
// Drives clear, append, check and read back operations into the allow/block
// range filter. A local copy of both tables predicts every result, and each
// result transfer is checked against the oldest prediction. Idling on both
// sides rotates through phases so that gaps fall on every part of the work.
// ----------------------------------------------------------------------------
module tb;
  import iprf_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEFAULT;
  localparam int TOTAL_ITEMS  = 425;
  localparam int PHASE_LEN    = 60;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;

  localparam logic SEL_ALLOW = 1'b0;
  localparam logic SEL_BLOCK = 1'b1;

  // Codes past the last defined operation; the block must answer them with
  // an empty result and leave both tables alone.
  localparam logic [OP_W-1:0] OP_UNKNOWN_LO = OP_READ + 3'd1;
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

  typedef enum int {
    PH_NONE,
    PH_SENDER,
    PH_RECEIVER,
    PH_BOTH
  } idle_phase_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      drv_valid = 1'b0;
  in_item_t  drv_item  = '0;
  logic      rx_stall  = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Shadow copy of both tables, indexed by table select.
  logic [ADDR_W-1:0] tbl_first [2][DEPTH];
  logic [ADDR_W-1:0] tbl_last  [2][DEPTH];
  int unsigned       tbl_used  [2] = '{0, 0};

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int unsigned items_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  ip_range_allow_block_filter_unit #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (drv_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (drv_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (rx_stall),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Scan the visible entries of one table for an inclusive hit. A reversed
  // range can never satisfy both compares, so it never hits.
  function automatic logic range_hit(logic sel, logic [ADDR_W-1:0] addr);
    for (int k = 0; k < tbl_used[sel]; k++) begin
      if (tbl_first[sel][k] <= addr && addr <= tbl_last[sel][k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow tables and queue its results.
  function automatic void predict_results(in_item_t it);
    out_item_t   r;
    logic        sel;
    int unsigned used;
    int unsigned avail;
    int unsigned n;
    sel  = it.table_select;
    used = tbl_used[sel];
    r    = '0;
    r.final_item = 1'b1;
    case (it.operation)
      OP_CLEAR: begin
        // Drop the count only; old values stay but are hidden.
        tbl_used[sel] = 0;
      end
      OP_APPEND: begin
        if (used >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          tbl_first[sel][used] = it.range_start;
          tbl_last[sel][used]  = it.range_end;
          tbl_used[sel]        = used + 1;
        end
      end
      OP_CHECK_ALIVE: begin
        r.matched = !range_hit(SEL_BLOCK, it.address) && range_hit(SEL_ALLOW, it.address);
      end
      OP_CHECK_ONE: begin
        r.matched = range_hit(sel, it.address);
      end
      OP_READ: begin
        // Clip the run to the stored entries and to the longest read.
        avail = (it.entry_index < used) ? used - it.entry_index : 0;
        n     = (it.entry_count < avail) ? it.entry_count : avail;
        if (n > MAX_READ) n = MAX_READ;
        for (int k = 0; k < n; k++) begin
          r.entry_first    = tbl_first[sel][it.entry_index + k];
          r.entry_last     = tbl_last[sel][it.entry_index + k];
          r.returned_count = CNT_FIELD_W'(n);
          r.final_item     = (k + 1 == n);
          expected_results = {expected_results, r};
        end
        if (n != 0) return;
      end
      default: begin
      end
    endcase
    expected_results = {expected_results, r};
  endfunction

  // --------------------------------------------------------------------------
  // Idling phases
  // --------------------------------------------------------------------------

  // Rotate the idling phase every PHASE_LEN accepted transfers; the directed
  // part falls in the phase without idling.
  function automatic int idle_pct(logic receiver);
    idle_phase_e ph;
    ph = idle_phase_e'((items_accepted / PHASE_LEN) % 4);
    case (ph)
      PH_SENDER:   return receiver ? 0 : 46;
      PH_RECEIVER: return receiver ? 46 : 0;
      PH_BOTH:     return 15;
      default:     return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold the payload while stalled, advance after each transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && !in_stall_o) begin
        predict_results(drv_item);
        items_accepted <= items_accepted + 1;
      end
      if (!drv_valid || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          drv_item  <= pending_items.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, drawn fresh every cycle.
  always @(posedge clk_i) begin
    rx_stall <= rst_ni && ($urandom_range(0, 99) < idle_pct(1'b1));
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic string fmt_result(out_item_t r);
    return $sformatf("matched=%0d status=%0d first=%h last=%h count=%0d final=%0d",
                     r.matched, r.status, r.entry_first, r.entry_last,
                     r.returned_count, r.final_item);
  endfunction

  function automatic void log_mismatch(string why, out_item_t exp_r, out_item_t act_r);
    if (mismatches < MAX_REPORTS) begin
      $display("%s: expected %s", why, fmt_result(exp_r));
      $display("%s:   actual %s", why, fmt_result(act_r));
    end
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && !rx_stall) begin
      if (expected_results.size() == 0) begin
        log_mismatch("unexpected result", '0, out_item_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item_o.matched !== exp_r.matched ||
            out_item_o.status !== exp_r.status ||
            out_item_o.entry_first !== exp_r.entry_first ||
            out_item_o.entry_last !== exp_r.entry_last ||
            out_item_o.returned_count !== exp_r.returned_count ||
            out_item_o.final_item !== exp_r.final_item) begin
          log_mismatch("result mismatch", exp_r, out_item_o);
        end
      end
    end
  end

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ip_range_allow_block_filter_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_op(logic [OP_W-1:0] op, logic sel, logic [ADDR_W-1:0] rs,
                          logic [ADDR_W-1:0] re, logic [ADDR_W-1:0] addr,
                          logic [IDX_W-1:0] idx, logic [CNT_FIELD_W-1:0] cnt);
    in_item_t it;
    it.operation    = op;
    it.table_select = sel;
    it.range_start  = rs;
    it.range_end    = re;
    it.address      = addr;
    it.entry_index  = idx;
    it.entry_count  = cnt;
    pending_items   = {pending_items, it};
  endtask

  // Draw a range: mostly narrow, some wide, a few reversed, covering all or single-address.
  task automatic pick_range(output logic [ADDR_W-1:0] lo, output logic [ADDR_W-1:0] hi);
    int unsigned shape;
    shape = $urandom_range(0, 99);
    lo    = $urandom;
    if (shape < 55) begin
      hi = lo + $urandom_range(0, 255);
    end else if (shape < 80) begin
      hi = lo + ($urandom >> $urandom_range(0, 31));
    end else if (shape < 92) begin
      hi = lo - $urandom_range(1, 1000);
    end else if (shape < 96) begin
      lo = '0;
      hi = '1;
    end else begin
      hi = lo;
    end
  endtask

  initial begin : stimulus
    int unsigned       seq_no;
    int unsigned       n_app;
    int unsigned       pick;
    logic              sel;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] seq_lo [8];
    logic [ADDR_W-1:0] seq_hi [8];
    logic [ADDR_W-1:0] addr;

    // Directed part: empty tables, extremes, reversed and single-address
    // ranges, clipped and empty read backs, unknown codes.
    queue_op(OP_CLEAR, SEL_ALLOW, '0, '0, '0, '0, '0);
    queue_op(OP_CLEAR, SEL_BLOCK, '1, '1, '1, '1, '1);
    queue_op(OP_CHECK_ALIVE, SEL_ALLOW, '0, '0, '0, '0, '0);
    queue_op(OP_READ, SEL_ALLOW, '0, '0, '0, '0, MAX_READ);
    queue_op(OP_APPEND, SEL_ALLOW, '0, '1, '0, '0, '0);
    queue_op(OP_APPEND, SEL_ALLOW, '1, '0, '0, '0, '0);
    queue_op(OP_APPEND, SEL_ALLOW, 32'h0A00_0001, 32'h0A00_0001, '0, '0, '0);
    queue_op(OP_APPEND, SEL_BLOCK, 32'hC0A8_0000, 32'hC0A8_FFFF, '0, '0, '0);
    queue_op(OP_APPEND, SEL_BLOCK, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
    queue_op(OP_CHECK_ALIVE, SEL_BLOCK, '0, '0, 32'hC0A8_0101, '0, '0);
    queue_op(OP_CHECK_ALIVE, SEL_ALLOW, '0, '0, '1, '0, '0);
    queue_op(OP_CHECK_ALIVE, SEL_ALLOW, '0, '0, 32'h8000_0000, '0, '0);
    queue_op(OP_CHECK_ONE, SEL_ALLOW, '0, '0, 32'h0A00_0001, '0, '0);
    queue_op(OP_CHECK_ONE, SEL_BLOCK, '0, '0, 32'hC0A8_FFFF, '0, '0);
    queue_op(OP_CHECK_ONE, SEL_BLOCK, '0, '0, 32'hC0A9_0000, '0, '0);
    queue_op(OP_CHECK_ONE, SEL_BLOCK, '0, '0, 32'h7FFF_FFFF, '0, '0);
    queue_op(OP_READ, SEL_ALLOW, '0, '0, '0, '0, MAX_READ);
    queue_op(OP_READ, SEL_ALLOW, '0, '0, '0, 6'd1, 7'd1);
    queue_op(OP_READ, SEL_ALLOW, '0, '0, '0, 6'd2, '0);
    queue_op(OP_READ, SEL_BLOCK, '1, '1, '1, '1, MAX_READ);
    for (int k = OP_UNKNOWN_LO; k <= OP_UNKNOWN_HI; k++) begin
      queue_op(OP_W'(k), 1'($urandom), $urandom, $urandom, $urandom,
               IDX_W'($urandom), CNT_FIELD_W'($urandom_range(0, 64)));
    end
    queue_op(OP_CLEAR, SEL_BLOCK, '0, '0, '0, '0, '0);
    queue_op(OP_CHECK_ALIVE, SEL_BLOCK, '0, '0, 32'hC0A8_0101, '0, '0);
    queue_op(OP_READ, SEL_BLOCK, '0, '0, '0, '0, 7'd5);

    // Random part: mostly clear/append/check/read sequences built around the
    // ranges just appended, with a full fill of each table and some noise.
    seq_no = 0;
    while (pending_items.size() < TOTAL_ITEMS) begin
      seq_no++;
      sel = 1'($urandom);
      if (seq_no == 4 || seq_no == 25) begin
        // Fill a table past its depth so the last appends are dropped.
        sel = (seq_no == 4) ? SEL_ALLOW : SEL_BLOCK;
        queue_op(OP_CLEAR, sel, $urandom, $urandom, $urandom, '0, '0);
        for (int k = 0; k < DEPTH + 2; k++) begin
          pick_range(lo, hi);
          queue_op(OP_APPEND, sel, lo, hi, $urandom, IDX_W'($urandom), '0);
        end
        for (int k = 0; k < 3; k++) begin
          queue_op(OP_CHECK_ALIVE, 1'($urandom), '0, '0, $urandom, '0, '0);
        end
        queue_op(OP_READ, sel, $urandom, $urandom, $urandom, '0, MAX_READ);
        queue_op(OP_READ, sel, $urandom, $urandom, $urandom, '1, MAX_READ);
        queue_op(OP_READ, sel, $urandom, $urandom, $urandom, 6'd40, 7'd30);
      end else if ($urandom_range(0, 99) < 15) begin
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
          queue_op(OP_W'($urandom_range(0, 7)), 1'($urandom), $urandom, $urandom,
                   $urandom, IDX_W'($urandom), CNT_FIELD_W'($urandom_range(0, 64)));
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          queue_op(OP_CLEAR, sel, $urandom, $urandom, $urandom, '0, '0);
        end
        n_app = $urandom_range(1, 8);
        for (int k = 0; k < n_app; k++) begin
          pick_range(seq_lo[k], seq_hi[k]);
          queue_op(OP_APPEND, sel, seq_lo[k], seq_hi[k], $urandom, '0, '0);
        end
        for (int k = $urandom_range(3, 6); k > 0; k--) begin
          // Probe the edges of a fresh range, just inside and just outside, its middle or a random address.
          pick = $urandom_range(0, n_app - 1);
          case ($urandom_range(0, 5))
            0:       addr = seq_lo[pick];
            1:       addr = seq_hi[pick];
            2:       addr = seq_lo[pick] - 1;
            3:       addr = seq_hi[pick] + 1;
            4:       addr = seq_lo[pick] + ((seq_hi[pick] - seq_lo[pick]) >> 1);
            default: addr = $urandom;
          endcase
          queue_op(($urandom_range(0, 1) == 0) ? OP_CHECK_ALIVE : OP_CHECK_ONE,
                   1'($urandom), '0, '0, addr, '0, '0);
        end
        for (int k = $urandom_range(1, 2); k > 0; k--) begin
          queue_op(OP_READ, sel, '0, '0, '0,
                   IDX_W'($urandom_range(0, 12)), CNT_FIELD_W'($urandom_range(0, 64)));
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to come back,
    // then give the block time to show any stray result.
    do @(posedge clk_i);
    while (pending_items.size() != 0 || drv_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (expected_results.size() != 0) begin
      log_mismatch("missing result", expected_results.pop_front(), '0);
    end

    if (mismatches == 0) begin
      $display("[ip_range_allow_block_filter_unit] OK");
    end else begin
      $display("[ip_range_allow_block_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
